// ----- rtl/lcd_panel_power_up_sequencer_core_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the panel power-up sequencer
// Shared property forms; they expect clk and arst_n in the using scope.
// ----------------------------------------------------------------------------
`ifndef LCD_PANEL_POWER_UP_SEQUENCER_CORE_DEFINES_SVH
`define LCD_PANEL_POWER_UP_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication
`define LPPS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define LPPS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/lpps_pkg.sv -----
// ----------------------------------------------------------------------------
// lpps_pkg
// Types, timing constants and the register set-up script of the sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpps_pkg;

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_RESET_LOW  = 3'd1,
		PH_RESET_HIGH = 3'd2,
		PH_SLEEP_OUT  = 3'd3,
		PH_CONFIG     = 3'd4,
		PH_DISPLAY_ON = 3'd5,
		PH_DONE       = 3'd6
	} phase_t;

	typedef enum logic [1:0] {
		JOB_STATUS  = 2'd0,
		JOB_SLEEP   = 2'd1,
		JOB_SETUP   = 2'd2,
		JOB_DISPLAY = 2'd3
	} job_kind_t;

	typedef struct packed {
		phase_t      phase;
		logic [31:0] start;
		logic        rst_line;
	} st_t;

	typedef struct packed {
		job_kind_t kind;
		logic      ready;
		logic      reset_level;
	} job_t;

	typedef struct packed {
		logic [7:0]  orientation;
		logic [11:0] col_off;
		logic [11:0] row_off;
		logic [11:0] width;
		logic [11:0] height;
	} panel_cfg_t;

	localparam logic MODE_START = 1'b0;

	localparam logic [2:0] REG_ORIENT = 3'd0;
	localparam logic [2:0] REG_COL    = 3'd1;
	localparam logic [2:0] REG_ROW    = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	localparam logic [31:0] DLY_RESET   = 32'd10;
	localparam logic [31:0] DLY_SLEEP   = 32'd5;
	localparam logic [31:0] DLY_CONFIG  = 32'd120;
	localparam logic [31:0] DLY_DISPLAY = 32'd20;

	localparam st_t ST_RESET = '{phase: PH_IDLE, start: 32'd0, rst_line: 1'b1};

	localparam logic [7:0] CMD_SLPOUT = 8'h11;
	localparam logic [7:0] CMD_INVON  = 8'h21;
	localparam logic [7:0] CMD_DISPON = 8'h29;
	localparam logic [7:0] CMD_CASET  = 8'h2A;
	localparam logic [7:0] CMD_RASET  = 8'h2B;
	localparam logic [7:0] CMD_RAMWR  = 8'h2C;

	// set-up script: bit 8 = parameter byte, bit 9 = take orientation from config
	localparam int SETUP_LEN = 61;
	localparam logic [5:0] SETUP_LAST = 6'(SETUP_LEN - 1);
	localparam logic [9:0] SETUP_ROM [0:SETUP_LEN-1] = '{
		10'h020,
		10'h0B2, 10'h10C, 10'h10C, 10'h100, 10'h133, 10'h133,
		10'h020,
		10'h0B7, 10'h156,
		10'h0BB, 10'h118,
		10'h0C0, 10'h12C,
		10'h0C2, 10'h101,
		10'h0C3, 10'h11F,
		10'h0C4, 10'h120,
		10'h0C6, 10'h10F,
		10'h0D0, 10'h1A6, 10'h1A1,
		10'h0E0, 10'h1D0, 10'h10D, 10'h114, 10'h10B, 10'h10B, 10'h107,
		10'h13A, 10'h144, 10'h150, 10'h108, 10'h113, 10'h113, 10'h12D, 10'h132,
		10'h0E1, 10'h1D0, 10'h10D, 10'h114, 10'h10B, 10'h10B, 10'h107,
		10'h13A, 10'h144, 10'h150, 10'h108, 10'h113, 10'h113, 10'h12D, 10'h132,
		10'h036, 10'h300,
		10'h03A, 10'h155,
		10'h0E7, 10'h100
	};

	function automatic logic [9:0] setup_word(input logic [5:0] idx);
		logic [9:0] w;
		w = 10'h000;
		if (idx <= SETUP_LAST) begin
			w = SETUP_ROM[idx];
		end
		return w;
	endfunction

endpackage

// ----- rtl/lpps_state.sv -----
// ----------------------------------------------------------------------------
// lpps_state
// Phase state held in a one-entry synchronous memory; read on accept,
// updated and written back as the word moves on to the emitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpps_state (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          in_mode,
	input  logic [31:0]   in_now,
	output logic          job_valid,
	input  logic          job_free,
	output lpps_pkg::job_t job
);
	import lpps_pkg::*;

	st_t         st_mem [0:0];
	logic        st_valid_q;
	st_t         st_rd_s1;
	logic        st_ok_s1;
	logic        vld_s1;
	logic        mode_s1;
	logic [31:0] now_s1;

	st_t         st_cur;
	st_t         st_next;
	logic [31:0] elapsed;
	logic        accept;
	logic        adv;

	assign adv       = vld_s1 & job_free;
	assign in_ready  = ~vld_s1 | job_free;
	assign accept    = in_valid & in_ready;
	assign job_valid = vld_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			st_mem[0] <= st_next;
		end
	end

	// read with write-through so a word following straight on sees the update
	always_ff @(posedge clk) begin
		if (accept) begin
			st_rd_s1 <= adv ? st_next : st_mem[0];
			mode_s1  <= in_mode;
			now_s1   <= in_now;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid_q <= 1'b0;
			st_ok_s1   <= 1'b0;
			vld_s1     <= 1'b0;
		end else begin
			if (adv) begin
				st_valid_q <= 1'b1;
			end
			if (accept) begin
				st_ok_s1 <= adv | st_valid_q;
			end
			if (accept) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	assign st_cur  = st_ok_s1 ? st_rd_s1 : ST_RESET;
	assign elapsed = now_s1 - st_cur.start;

	always_comb begin
		st_next   = st_cur;
		job.kind  = JOB_STATUS;
		job.ready = 1'b0;
		if (mode_s1 == MODE_START) begin
			st_next.phase = PH_RESET_LOW;
			st_next.start = 32'd0;
		end else begin
			unique case (st_cur.phase)
				PH_IDLE: begin
				end
				PH_RESET_LOW: begin
					st_next.rst_line = 1'b0;
					st_next.start    = now_s1;
					st_next.phase    = PH_RESET_HIGH;
				end
				PH_RESET_HIGH: begin
					if (elapsed >= DLY_RESET) begin
						st_next.rst_line = 1'b1;
						st_next.start    = now_s1;
						st_next.phase    = PH_SLEEP_OUT;
					end
				end
				PH_SLEEP_OUT: begin
					if (elapsed >= DLY_SLEEP) begin
						job.kind      = JOB_SLEEP;
						st_next.start = now_s1;
						st_next.phase = PH_CONFIG;
					end
				end
				PH_CONFIG: begin
					if (elapsed >= DLY_CONFIG) begin
						job.kind      = JOB_SETUP;
						st_next.start = now_s1;
						st_next.phase = PH_DISPLAY_ON;
					end
				end
				PH_DISPLAY_ON: begin
					if (elapsed >= DLY_DISPLAY) begin
						job.kind      = JOB_DISPLAY;
						job.ready     = 1'b1;
						st_next.phase = PH_DONE;
					end
				end
				PH_DONE: begin
					job.ready = 1'b1;
				end
				default: begin
					st_next.phase = PH_IDLE;
				end
			endcase
		end
		job.reset_level = st_next.rst_line;
	end

endmodule

// ----- rtl/lpps_emit.sv -----
// ----------------------------------------------------------------------------
// lpps_emit
// Expands a job into words in an output register, one per cycle if unstalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpps_emit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                job_valid,
	output logic                job_free,
	input  lpps_pkg::job_t      job,
	input  lpps_pkg::panel_cfg_t cfg,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                out_reset_level,
	output logic                out_has_byte,
	output logic                out_is_data,
	output logic [7:0]          out_byte,
	output logic                out_last,
	output logic                out_ready_res
);
	import lpps_pkg::*;

	job_t        job_q;
	logic        job_vld_q;
	logic [5:0]  idx_q;

	logic        load;
	logic        w_last;
	logic        w_is_data;
	logic [7:0]  w_byte;
	logic [5:0]  last_idx;
	logic        win_en;
	logic [12:0] x_end;
	logic [12:0] y_end;
	logic [9:0]  rom_w;

	assign win_en = (cfg.width != 12'd0) && (cfg.height != 12'd0);
	assign x_end  = {1'b0, cfg.width} + {1'b0, cfg.col_off} - 13'd1;
	assign y_end  = {1'b0, cfg.height} + {1'b0, cfg.row_off} - 13'd1;
	assign rom_w  = setup_word(idx_q);

	always_comb begin
		unique case (job_q.kind)
			JOB_STATUS:  last_idx = 6'd0;
			JOB_SLEEP:   last_idx = 6'd0;
			JOB_SETUP:   last_idx = SETUP_LAST;
			JOB_DISPLAY: last_idx = win_en ? 6'd12 : 6'd1;
		endcase
	end

	always_comb begin
		w_is_data = 1'b0;
		w_byte    = 8'h00;
		unique case (job_q.kind)
			JOB_STATUS: begin
			end
			JOB_SLEEP: begin
				w_byte = CMD_SLPOUT;
			end
			JOB_SETUP: begin
				w_is_data = rom_w[8];
				w_byte    = rom_w[9] ? cfg.orientation : rom_w[7:0];
			end
			JOB_DISPLAY: begin
				w_is_data = 1'b1;
				unique case (idx_q)
					6'd0:  begin w_is_data = 1'b0; w_byte = CMD_INVON;  end
					6'd1:  begin w_is_data = 1'b0; w_byte = CMD_DISPON; end
					6'd2:  begin w_is_data = 1'b0; w_byte = CMD_CASET;  end
					6'd3:  w_byte = {4'h0, cfg.col_off[11:8]};
					6'd4:  w_byte = cfg.col_off[7:0];
					6'd5:  w_byte = {3'b000, x_end[12:8]};
					6'd6:  w_byte = x_end[7:0];
					6'd7:  begin w_is_data = 1'b0; w_byte = CMD_RASET;  end
					6'd8:  w_byte = {4'h0, cfg.row_off[11:8]};
					6'd9:  w_byte = cfg.row_off[7:0];
					6'd10: w_byte = {3'b000, y_end[12:8]};
					6'd11: w_byte = y_end[7:0];
					default: begin w_is_data = 1'b0; w_byte = CMD_RAMWR; end
				endcase
			end
		endcase
	end

	assign w_last   = (idx_q == last_idx);
	assign load     = job_vld_q & (~out_valid | out_ready);
	assign job_free = ~job_vld_q | (load & w_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			job_vld_q <= 1'b0;
			idx_q     <= 6'd0;
			out_valid <= 1'b0;
		end else begin
			if (job_free && job_valid) begin
				job_vld_q <= 1'b1;
				idx_q     <= 6'd0;
			end else if (load && w_last) begin
				job_vld_q <= 1'b0;
			end else if (load) begin
				idx_q <= idx_q + 6'd1;
			end
			if (load) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (job_free && job_valid) begin
			job_q <= job;
		end
		if (load) begin
			out_reset_level <= job_q.reset_level;
			out_has_byte    <= (job_q.kind != JOB_STATUS);
			out_is_data     <= w_is_data;
			out_byte        <= w_byte;
			out_last        <= w_last;
			out_ready_res   <= job_q.ready;
		end
	end

endmodule

// ----- rtl/lcd_panel_power_up_sequencer_core.sv -----
// ----------------------------------------------------------------------------
// lcd_panel_power_up_sequencer_core
// Timed reset, sleep-out, register set-up and display-on for an SPI TFT panel.
// ----------------------------------------------------------------------------
// A start word (tuser 0) arms the sequence; each poll word (tuser 1) carries the
// millisecond tick in tdata and may advance one phase. Start words and polls that
// send nothing give a single status word and are taken back to back, one per
// cycle while the output is not stalled; each word passes the state stage and the
// emitter's job and output registers. A poll that sends bytes holds the
// output for one word per byte: 1 (sleep-out), 61 (register set-up) and 2 or 13
// (display-on plus window) words, paced by the byte emitter; one further input
// word is taken and held meanwhile. Phase, phase start time and the reset line
// live in a one-entry state memory read as a word is taken and written back as
// it passes to the emitter, with the write forwarded to a word taken that cycle.
// No clearing pass is needed after reset. Configuration is accepted every cycle
// and should only change while the block is idle.
`timescale 1ns / 1ps
`include "lcd_panel_power_up_sequencer_core_defines.svh"

module lcd_panel_power_up_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] now_ms
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [0] reset_level, [1] has_byte, [9:2] byte_value,
	                               // [10] ready_res, [15:11] zero
	output logic        m_tuser,   // [0] is_data
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import lpps_pkg::*;

	panel_cfg_t cfg_q;
	job_t       job;
	logic       job_valid;
	logic       job_free;
	logic       o_reset_level;
	logic       o_has_byte;
	logic [7:0] o_byte;
	logic       o_ready_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.orientation <= 8'd0;
			cfg_q.col_off     <= 12'd0;
			cfg_q.row_off     <= 12'd0;
			cfg_q.width       <= 12'd240;
			cfg_q.height      <= 12'd320;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ORIENT: cfg_q.orientation <= cfg_data[7:0];
				REG_COL:    cfg_q.col_off     <= cfg_data;
				REG_ROW:    cfg_q.row_off     <= cfg_data;
				REG_WIDTH:  cfg_q.width       <= cfg_data;
				REG_HEIGHT: cfg_q.height      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	lpps_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_mode   (s_tuser),
		.in_now    (s_tdata),
		.job_valid (job_valid),
		.job_free  (job_free),
		.job       (job)
	);

	lpps_emit u_emit (
		.clk             (clk),
		.arst_n          (arst_n),
		.job_valid       (job_valid),
		.job_free        (job_free),
		.job             (job),
		.cfg             (cfg_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_reset_level (o_reset_level),
		.out_has_byte    (o_has_byte),
		.out_is_data     (m_tuser),
		.out_byte        (o_byte),
		.out_last        (m_tlast),
		.out_ready_res   (o_ready_res)
	);

	assign m_tdata = {5'b00000, o_ready_res, o_byte, o_has_byte, o_reset_level};

	// ready is only ever reported with the panel out of reset
	`LPPS_ASSERT_IMP(a_ready_released, m_tvalid && o_ready_res, o_reset_level,
		"ready reported while panel reset asserted")
	// a status word is always alone and carries no byte
	`LPPS_ASSERT_IMP(a_status_alone, m_tvalid && !o_has_byte,
		m_tlast && !m_tuser && (o_byte == 8'h00), "malformed status word")
	// emitter check: after a waiting job meets a free slot, m_tvalid, job_valid or s_tready is high
	`LPPS_ASSERT_NXT(a_job_taken, job_valid && job_free, u_emit_busy_chk(),
		"job not taken by emitter")

	function automatic logic u_emit_busy_chk();
		return m_tvalid | job_valid | s_tready;
	endfunction

endmodule

// ----- dv/lcd_panel_power_up_sequencer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcd_panel_power_up_sequencer_core_tb
// Self-checking bench for the panel power-up sequencer. A queue-fed driver
// offers start and poll words, a local copy of the sequencer predicts the
// panel bytes and status of every word taken, and a monitor compares each
// output word against the oldest prediction. Configuration changes only
// between rounds, once the block has drained.
// ----------------------------------------------------------------------------

module lcd_panel_power_up_sequencer_core_tb;

	import lpps_pkg::*;

	localparam logic MODE_POLL = !MODE_START;

	localparam logic [31:0] WAIT_RESET   = 32'd10;
	localparam logic [31:0] WAIT_SLEEP   = 32'd5;
	localparam logic [31:0] WAIT_CONFIG  = 32'd120;
	localparam logic [31:0] WAIT_DISPLAY = 32'd20;

	localparam logic [7:0] OP_SLEEP_OUT = 8'h11;
	localparam logic [7:0] OP_INV_ON    = 8'h21;
	localparam logic [7:0] OP_DISP_ON   = 8'h29;
	localparam logic [7:0] OP_COL_ADDR  = 8'h2A;
	localparam logic [7:0] OP_ROW_ADDR  = 8'h2B;
	localparam logic [7:0] OP_MEM_WRITE = 8'h2C;

	localparam int SETTLE_CYCLES = 8;
	localparam int LONG_HOLD     = 300;

	// bit 8: parameter byte; ORIENT_MARK takes the orientation register
	localparam logic [9:0] ORIENT_MARK = 10'h200;
	localparam logic [9:0] INIT_SCRIPT [0:60] = '{
		10'h020,
		10'h0B2, 10'h10C, 10'h10C, 10'h100, 10'h133, 10'h133,
		10'h020,
		10'h0B7, 10'h156,
		10'h0BB, 10'h118,
		10'h0C0, 10'h12C,
		10'h0C2, 10'h101,
		10'h0C3, 10'h11F,
		10'h0C4, 10'h120,
		10'h0C6, 10'h10F,
		10'h0D0, 10'h1A6, 10'h1A1,
		10'h0E0, 10'h1D0, 10'h10D, 10'h114, 10'h10B, 10'h10B, 10'h107,
		10'h13A, 10'h144, 10'h150, 10'h108, 10'h113, 10'h113, 10'h12D, 10'h132,
		10'h0E1, 10'h1D0, 10'h10D, 10'h114, 10'h10B, 10'h10B, 10'h107,
		10'h13A, 10'h144, 10'h150, 10'h108, 10'h113, 10'h113, 10'h12D, 10'h132,
		10'h036, ORIENT_MARK,
		10'h03A, 10'h155,
		10'h0E7, 10'h100
	};

	typedef struct packed {
		logic        mode;
		logic [31:0] now;
	} tick_word_t;

	typedef struct packed {
		logic       rst_lvl;
		logic       has_byte;
		logic       is_data;
		logic [7:0] val;
		logic       last;
		logic       ready;
	} panel_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;   // [31:0] now_ms
	logic        s_tuser = 1'b0; // [0] mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // [0] reset_level, [1] has_byte, [9:2] byte_value,
	                             // [10] ready_res, [15:11] zero
	logic        m_tuser;        // [0] is_data
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [11:0] cfg_data = '0;

	lcd_panel_power_up_sequencer_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20_000_000;
		$display("lcd_panel_power_up_sequencer_core regression: fail");
		$finish;
	end

	// sequencer copy used for prediction
	logic [7:0]  cfg_orient = 8'd0;
	logic [11:0] cfg_col_off = 12'd0;
	logic [11:0] cfg_row_off = 12'd0;
	logic [11:0] cfg_width = 12'd240;
	logic [11:0] cfg_height = 12'd320;
	phase_t      seq_phase = PH_IDLE;
	logic [31:0] seq_start = '0;
	logic        seq_rst = 1'b1;

	tick_word_t  tick_queue [$];
	panel_word_t due_words [$];
	panel_word_t burst [$];
	panel_word_t head_word;
	tick_word_t  next_tick;

	int mismatches = 0;
	int offered = 0;
	int taken = 0;
	int idle_odds = 3;
	int tx_gap = 0;
	int rx_gap = 0;
	int hold_asks = 0;
	int hold_seen = 0;
	int hold_left = 0;
	logic in_taken = 1'b0;

	task automatic flag_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		$display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what,
			got, want);
		mismatches++;
	endtask

	function automatic void apply_reg(input logic [2:0] idx, input logic [11:0] val);
		case (idx)
			REG_ORIENT: cfg_orient = val[7:0];
			REG_COL:    cfg_col_off = val;
			REG_ROW:    cfg_row_off = val;
			REG_WIDTH:  cfg_width = val;
			REG_HEIGHT: cfg_height = val;
			default: begin
			end
		endcase
	endfunction

	function automatic void push_byte(input logic is_data, input logic [7:0] val);
		panel_word_t w;
		w = '0;
		w.has_byte = 1'b1;
		w.is_data = is_data;
		w.val = val;
		burst.push_back(w);
	endfunction

	function automatic void push_pair(input logic [15:0] v);
		push_byte(1'b1, v[15:8]);
		push_byte(1'b1, v[7:0]);
	endfunction

	function automatic void advance_sequencer(input logic mode, input logic [31:0] now);
		logic [31:0] elapsed;
		logic        rdy;
		elapsed = now - seq_start;
		rdy = 1'b0;
		burst.delete();
		if (mode == MODE_START) begin
			seq_phase = PH_RESET_LOW;
			seq_start = '0;
		end else begin
			case (seq_phase)
				PH_IDLE: begin
				end
				PH_RESET_LOW: begin
					seq_rst = 1'b0;
					seq_start = now;
					seq_phase = PH_RESET_HIGH;
				end
				PH_RESET_HIGH: begin
					if (elapsed >= WAIT_RESET) begin
						seq_rst = 1'b1;
						seq_start = now;
						seq_phase = PH_SLEEP_OUT;
					end
				end
				PH_SLEEP_OUT: begin
					if (elapsed >= WAIT_SLEEP) begin
						push_byte(1'b0, OP_SLEEP_OUT);
						seq_start = now;
						seq_phase = PH_CONFIG;
					end
				end
				PH_CONFIG: begin
					if (elapsed >= WAIT_CONFIG) begin
						foreach (INIT_SCRIPT[i]) begin
							if (INIT_SCRIPT[i] == ORIENT_MARK) begin
								push_byte(1'b1, cfg_orient);
							end else begin
								push_byte(INIT_SCRIPT[i][8], INIT_SCRIPT[i][7:0]);
							end
						end
						seq_start = now;
						seq_phase = PH_DISPLAY_ON;
					end
				end
				PH_DISPLAY_ON: begin
					if (elapsed >= WAIT_DISPLAY) begin
						push_byte(1'b0, OP_INV_ON);
						push_byte(1'b0, OP_DISP_ON);
						// an empty panel gets no address window
						if (cfg_width != 12'd0 && cfg_height != 12'd0) begin
							push_byte(1'b0, OP_COL_ADDR);
							push_pair({4'd0, cfg_col_off});
							push_pair({4'd0, cfg_width} - 16'd1 + {4'd0, cfg_col_off});
							push_byte(1'b0, OP_ROW_ADDR);
							push_pair({4'd0, cfg_row_off});
							push_pair({4'd0, cfg_height} - 16'd1 + {4'd0, cfg_row_off});
							push_byte(1'b0, OP_MEM_WRITE);
						end
						seq_phase = PH_DONE;
						rdy = 1'b1;
					end
				end
				PH_DONE: rdy = 1'b1;
				default: seq_phase = PH_IDLE;
			endcase
		end
		if (burst.size() == 0) begin
			burst.push_back('0);
		end
		foreach (burst[k]) begin
			burst[k].rst_lvl = seq_rst;
			burst[k].last = (k == burst.size() - 1);
			burst[k].ready = rdy;
			due_words.push_back(burst[k]);
		end
	endfunction

	// input side: prediction on every word taken
	always @(posedge clk) begin
		in_taken <= arst_n && s_tvalid && s_tready;
		if (arst_n && s_tvalid && s_tready) begin
			advance_sequencer(s_tuser, s_tdata);
			taken++;
		end
	end

	// output side
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (due_words.size() == 0) begin
				flag_mismatch("word with nothing due", m_tdata, 16'd0);
			end else begin
				head_word = due_words.pop_front();
				if (m_tdata[0] !== head_word.rst_lvl)
					flag_mismatch("reset_level", 16'(m_tdata[0]), 16'(head_word.rst_lvl));
				if (m_tdata[1] !== head_word.has_byte)
					flag_mismatch("has_byte", 16'(m_tdata[1]), 16'(head_word.has_byte));
				if (m_tdata[9:2] !== head_word.val)
					flag_mismatch("byte_value", 16'(m_tdata[9:2]), 16'(head_word.val));
				if (m_tdata[10] !== head_word.ready)
					flag_mismatch("ready_res", 16'(m_tdata[10]), 16'(head_word.ready));
				if (m_tdata[15:11] !== 5'd0)
					flag_mismatch("tdata padding", 16'(m_tdata[15:11]), 16'd0);
				if (m_tuser !== head_word.is_data)
					flag_mismatch("is_data", 16'(m_tuser), 16'(head_word.is_data));
				if (m_tlast !== head_word.last)
					flag_mismatch("last", 16'(m_tlast), 16'(head_word.last));
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			// word still waiting for the handshake
		end else if (tx_gap > 0) begin
			tx_gap <= tx_gap - 1;
			s_tvalid <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
			tx_gap <= $urandom_range(0, 8);
			s_tvalid <= 1'b0;
		end else if (tick_queue.size() != 0) begin
			next_tick = tick_queue.pop_front();
			s_tvalid <= 1'b1;
			s_tuser <= next_tick.mode;
			s_tdata <= next_tick.now;
			offered++;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap <= rx_gap - 1;
			m_tready <= 1'b0;
		end else if (idle_odds != 0 && $urandom_range(0, idle_odds) == 0) begin
			rx_gap <= $urandom_range(0, 8);
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic queue_tick(input logic mode, input logic [31:0] now);
		tick_word_t w;
		w.mode = mode;
		w.now = now;
		tick_queue.push_back(w);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [11:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, val);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_panel(input logic [11:0] orient, input logic [11:0] col,
		input logic [11:0] row, input logic [11:0] width, input logic [11:0] height);
		write_reg(REG_ORIENT, orient);
		write_reg(REG_COL, col);
		write_reg(REG_ROW, row);
		write_reg(REG_WIDTH, width);
		write_reg(REG_HEIGHT, height);
	endtask

	task automatic wait_settled();
		@(negedge clk);
		while (tick_queue.size() != 0 || offered != taken || due_words.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// time steps mix just-short and generous advances so each phase is hit both ways
	function automatic logic [31:0] tick_step();
		logic [31:0] s;
		case ($urandom_range(0, 3))
			0: s = $urandom_range(0, 3);
			1: s = $urandom_range(0, 12);
			2: s = $urandom_range(4, 25);
			default: s = $urandom_range(100, 140);
		endcase
		return s;
	endfunction

	task automatic push_sequence(input int polls, output int n);
		logic [31:0] t;
		if ($urandom_range(0, 3) == 0) begin
			t = 32'hFFFF_FF00 + $urandom_range(0, 255);
		end else begin
			t = $urandom();
		end
		queue_tick(MODE_START, $urandom());
		for (int k = 0; k < polls; k++) begin
			queue_tick(MODE_POLL, t);
			t = t + tick_step();
		end
		n = polls + 1;
	endtask

	initial begin
		int made;
		int n;
		int pick;

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset configuration: polls while idle, each phase just short and just due,
		// a wrap of the tick counter, and restarts from done and mid-sequence
		queue_tick(MODE_POLL, 32'h0000_0000);
		queue_tick(MODE_POLL, 32'hFFFF_FFFF);
		queue_tick(MODE_START, 32'hFFFF_FFFF);
		queue_tick(MODE_POLL, 32'hFFFF_FFF8);
		queue_tick(MODE_POLL, 32'hFFFF_FFFF);
		queue_tick(MODE_POLL, 32'd2);
		queue_tick(MODE_POLL, 32'd6);
		queue_tick(MODE_POLL, 32'd7);
		queue_tick(MODE_POLL, 32'd126);
		queue_tick(MODE_POLL, 32'd127);
		queue_tick(MODE_POLL, 32'd146);
		queue_tick(MODE_POLL, 32'd147);
		queue_tick(MODE_POLL, 32'd0);
		queue_tick(MODE_START, 32'd0);
		queue_tick(MODE_POLL, 32'd500);
		queue_tick(MODE_START, 32'd123);
		queue_tick(MODE_POLL, 32'd600);
		queue_tick(MODE_POLL, 32'd610);
		queue_tick(MODE_START, 32'h5555_5555);
		queue_tick(MODE_POLL, 32'hAAAA_AAAA);
		queue_tick(MODE_POLL, 32'h5555_5555);
		queue_tick(MODE_POLL, 32'hAAAA_AAAA);
		queue_tick(MODE_POLL, 32'h5555_5555);
		queue_tick(MODE_POLL, 32'hAAAA_AAAA);
		wait_settled();

		for (int round = 0; round < 7; round++) begin
			case (round)
				0: set_panel(12'h0FF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
				1: set_panel(12'h000, 12'h000, 12'h000, 12'h000, 12'h001);
				2: set_panel(12'h0A5, 12'h035, 12'h050, 12'h001, 12'h000);
				3: set_panel(12'h05A, 12'h000, 12'hFFF, 12'h001, 12'h001);
				default: begin
					set_panel(12'($urandom()), 12'($urandom()), 12'($urandom()),
						12'($urandom()), 12'($urandom()));
					// indexes past the register set must change nothing
					if (round == 4) begin
						for (int k = 1; k <= 3; k++)
							write_reg(REG_HEIGHT + 3'(k), 12'($urandom()));
					end
				end
			endcase
			case (round)
				6: idle_odds = 0;
				1, 4: idle_odds = 2;
				default: idle_odds = ($urandom_range(0, 1) == 0) ? 5 : 20;
			endcase
			// receiver goes quiet while the sender keeps offering
			if (round == 2) hold_asks++;
			made = 0;
			while (made < 42) begin
				pick = $urandom_range(0, 9);
				if (pick < 7) begin
					push_sequence($urandom_range(6, 14), n);
				end else if (pick < 9) begin
					for (int k = 0; k < 3; k++)
						queue_tick(1'($urandom_range(0, 1)), $urandom());
					n = 3;
				end else begin
					push_sequence($urandom_range(1, 4), n);
				end
				made += n;
			end
			wait_settled();
		end

		if (due_words.size() != 0) begin
			flag_mismatch("words never delivered", 16'(due_words.size()), 16'd0);
		end
		if (mismatches == 0) begin
			$display("lcd_panel_power_up_sequencer_core regression: pass");
		end else begin
			$display("lcd_panel_power_up_sequencer_core regression: fail");
		end
		$finish;
	end

endmodule
